// ===== rtl/bsg_pkg.sv =====
package bsg_pkg;

  localparam int MaxRanks   = 64;
  localparam int RankW      = 6;
  localparam int GroupW     = 7;
  localparam int CountW     = 24;
  localparam int EsizeW     = 7;
  localparam int TotalW     = 31;
  localparam int AmountW    = 30;
  localparam int ProdW      = RankW + TotalW;
  localparam int DivW       = TotalW + 1;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 31;

  localparam logic [TotalW-1:0] ShortReset = 31'd12288;
  localparam logic [TotalW-1:0] LongReset  = 31'd524288;
  localparam logic [GroupW-1:0] MinGrpReset = 7'd8;

  typedef enum logic [1:0] {
    OP_RECV = 2'd0,
    OP_SEND = 2'd1,
    OP_SENDRECV = 2'd2
  } op_kind_t;

  typedef enum logic [1:0] {
    ALG_TREE = 2'd0,
    ALG_DOUBLING = 2'd1,
    ALG_RING = 2'd2
  } alg_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHORT = 2'd0,
    CFG_LONG = 2'd1,
    CFG_MIN_GROUP = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         op_kind;
    logic [RankW-1:0]   send_peer;
    logic [RankW-1:0]   recv_peer;
    logic [AmountW-1:0] send_amount;
    logic [AmountW-1:0] recv_amount;
    logic [1:0]         algorithm;
    logic               last;
  } op_t;

  // Bytes of a block at byte offset off, capped at cap, floored at zero.
  function automatic logic [TotalW-1:0] piece(input logic [ProdW-1:0] off,
                                               input logic [TotalW-1:0] total,
                                               input logic [ProdW-1:0] cap);
    logic [ProdW-1:0] rest;
    rest = {{(ProdW-TotalW){1'b0}}, total} - off;
    if (off >= {{(ProdW-TotalW){1'b0}}, total}) begin
      piece = '0;
    end else if (rest < cap) begin
      piece = rest[TotalW-1:0];
    end else begin
      piece = cap[TotalW-1:0];
    end
  endfunction

  function automatic logic [AmountW-1:0] sat_amount(input logic [TotalW-1:0] v);
    sat_amount = v[TotalW-1] ? {AmountW{1'b1}} : v[AmountW-1:0];
  endfunction

endpackage

// ===== rtl/bsg_if.sv =====
interface bsg_req_if;
  logic                       valid;
  logic                       ready;
  logic [bsg_pkg::RankW-1:0]  my_rank;
  logic [bsg_pkg::RankW-1:0]  root_rank;
  logic [bsg_pkg::GroupW-1:0] group_size;
  logic [bsg_pkg::CountW-1:0] elem_count;
  logic [bsg_pkg::EsizeW-1:0] elem_bytes;
  modport source (output valid, my_rank, root_rank, group_size, elem_count, elem_bytes,
                  input ready);
  modport sink (input valid, my_rank, root_rank, group_size, elem_count, elem_bytes,
                output ready);
endinterface

interface bsg_op_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op_kind;
  logic [bsg_pkg::RankW-1:0]   send_peer;
  logic [bsg_pkg::RankW-1:0]   recv_peer;
  logic [bsg_pkg::AmountW-1:0] send_amount;
  logic [bsg_pkg::AmountW-1:0] recv_amount;
  logic [1:0]                  algorithm;
  logic                        last;
  modport source (output valid, op_kind, send_peer, recv_peer, send_amount, recv_amount,
                  algorithm, last, input ready);
  modport sink (input valid, op_kind, send_peer, recv_peer, send_amount, recv_amount,
                algorithm, last, output ready);
endinterface

// ===== rtl/bcast_schedule_generator_unit.sv =====
// Tree requests: checks and selection in S_CHK and S_SEL, then the first word leaves, followed
// by at most one word a cycle while the receiver keeps up.
// Allgather requests: the same checks and selection, a restoring division by the group size, then
// states S_DBL_M/S_DBL_E per doubling word and S_RING_M0/M1/E per ring word, via one shared multiplier.
// One request at a time; ready returns in the cycle after the last word moves to the output.
// Reset (synchronous, rst_n low) empties the pipeline and restores the threshold registers.
module bcast_schedule_generator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  bsg_req_if.sink                        in_req,
  bsg_op_if.source                       out_op,
  input  logic                           cfg_we,
  input  logic [bsg_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bsg_pkg::CfgDataW-1:0]   cfg_data
);
  import bsg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_SEL, S_TREE, S_DIV, S_DBL_INIT, S_DBL_H, S_DBL_M, S_DBL_E,
    S_RING_M0, S_RING_M1, S_RING_E, S_FLUSH
  } state_t;

  state_t state_r;

  logic [TotalW-1:0] short_r, long_r;
  logic [GroupW-1:0] min_grp_r;

  // Latched request.
  logic [RankW-1:0]  me_r, root_r;
  logic [GroupW-1:0] n_r;
  logic [CountW-1:0] count_r;
  logic [EsizeW-1:0] esize_r;

  logic [TotalW-1:0] total_r;
  logic [RankW-1:0]  rel_r;
  logic              bad_r;
  alg_t              alg_r;

  logic [GroupW-1:0] mask_r;
  logic [DivW-1:0]   d_r;
  logic [GroupW-1:0] rem_r;
  logic [4:0]        div_cnt_r;
  logic [TotalW-1:0] s_r;
  logic [ProdW-1:0]  prod_r;
  logic [ProdW-1:0]  cap_r;
  logic [TotalW-1:0] held_r;
  logic [TotalW-1:0] pa_r;
  logic [RankW-1:0]  rj_r;
  logic [GroupW-1:0] step_r;

  // Two-deep staging: hold_r keeps the newest word so that the final one can be tagged.
  op_t  hold_r, out_r, cand;
  logic hold_v_r, out_v_r;
  logic out_free, can_push, cand_push;

  // Combinational helpers.
  logic [GroupW:0]   rel_sum, rel_full;
  logic [RankW-1:0]  lowbit;
  logic [GroupW-1:0] top_mask;
  logic [GroupW:0]   src_sum, dst_sum, droot_sum;
  logic [RankW-1:0]  src_rank, dst_rank, dbl_peer;
  logic [RankW-1:0]  rdst, droot, rjn, mul_a;
  logic [ProdW-1:0]  mul_p;
  logic [TotalW-1:0] piece_v, posted;
  logic [RankW-1:0]  left_rank, right_rank;
  logic [GroupW:0]   div_t;
  logic              div_ge;
  logic [GroupW-1:0] n_m1;
  logic [TotalW-1:0] tree_amt;

  assign out_free = !out_v_r || out_op.ready;
  assign can_push = !hold_v_r || out_free;
  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    // Rank relative to the root, reduced modulo the group size.
    rel_sum  = {2'b00, me_r} + {1'b0, n_r} - {2'b00, root_r};
    rel_full = (rel_sum >= {1'b0, n_r}) ? rel_sum - {1'b0, n_r} : rel_sum;
    lowbit   = rel_r & (~rel_r + 6'd1);
    n_m1     = n_r - 7'd1;
    top_mask = '0;
    for (int b = 0; b < GroupW; b++) begin
      if (n_m1[b]) top_mask = 7'd1 << b;
    end
    // Parent in the tree: me - lowbit, wrapped.
    src_sum  = {2'b00, me_r} + {1'b0, n_r} - {2'b00, lowbit};
    src_rank = (src_sum >= {1'b0, n_r}) ? 6'(src_sum - {1'b0, n_r}) : src_sum[RankW-1:0];
    // Child in the tree: me + mask, wrapped.
    dst_sum  = {2'b00, me_r} + {1'b0, mask_r};
    dst_rank = (dst_sum >= {1'b0, n_r}) ? 6'(dst_sum - {1'b0, n_r}) : dst_sum[RankW-1:0];
    // Doubling partner and the root of its subtree.
    rdst      = rel_r ^ mask_r[RankW-1:0];
    droot     = rdst & ~(mask_r[RankW-1:0] - 6'd1);
    droot_sum = {2'b00, rdst} + {2'b00, root_r};
    dbl_peer  = (droot_sum >= {1'b0, n_r}) ? 6'(droot_sum - {1'b0, n_r})
                                           : droot_sum[RankW-1:0];
    rjn        = (rj_r == 6'd0) ? n_m1[RankW-1:0] : rj_r - 6'd1;
    left_rank  = (me_r == 6'd0) ? n_m1[RankW-1:0] : me_r - 6'd1;
    right_rank = ({1'b0, me_r} == n_m1) ? 6'd0 : me_r + 6'd1;

    case (state_r)
      S_DBL_INIT: mul_a = rel_r;
      S_DBL_M:    mul_a = droot;
      S_RING_M0:  mul_a = rj_r;
      S_RING_M1:  mul_a = rjn;
      default:    mul_a = '0;
    endcase
    mul_p = {{TotalW{1'b0}}, mul_a} * {{RankW{1'b0}}, s_r};

    piece_v = piece(prod_r, total_r, (state_r == S_DBL_E) ? cap_r
                                     : {{RankW{1'b0}}, s_r});
    posted  = (prod_r < {{RankW{1'b0}}, total_r}) ? 31'(({{RankW{1'b0}}, total_r}) - prod_r)
                                                 : '0;

    div_t  = {rem_r, d_r[DivW-1]};
    div_ge = div_t >= {1'b0, n_r};
    tree_amt = {{(TotalW-CountW){1'b0}}, count_r};

    cand = '0;
    cand_push = 1'b0;
    case (state_r)
      S_SEL: begin
        // The algorithm register is only loaded at the end of this cycle, so the tree
        // choice is tested directly here.
        if (!bad_r && (total_r < short_r || n_r < min_grp_r) && rel_r != 6'd0) begin
          cand_push = 1'b1;
          cand.op_kind = OP_RECV;
          cand.recv_peer = src_rank;
          cand.recv_amount = sat_amount(tree_amt);
          cand.algorithm = ALG_TREE;
        end
      end
      S_TREE: begin
        if (mask_r != '0 && ({2'b00, rel_r} + {1'b0, mask_r}) < {1'b0, n_r}) begin
          cand_push = 1'b1;
          cand.op_kind = OP_SEND;
          cand.send_peer = dst_rank;
          cand.send_amount = sat_amount(tree_amt);
          cand.algorithm = ALG_TREE;
        end
      end
      S_DBL_E: begin
        cand_push = 1'b1;
        cand.op_kind = OP_SENDRECV;
        cand.send_peer = dbl_peer;
        cand.recv_peer = dbl_peer;
        cand.send_amount = sat_amount(held_r);
        cand.recv_amount = sat_amount(posted);
        cand.algorithm = ALG_DOUBLING;
      end
      S_RING_E: begin
        cand_push = 1'b1;
        cand.op_kind = OP_SENDRECV;
        cand.send_peer = right_rank;
        cand.recv_peer = left_rank;
        cand.send_amount = sat_amount(pa_r);
        cand.recv_amount = sat_amount(piece_v);
        cand.algorithm = ALG_RING;
      end
      default: ;
    endcase
  end

  assign out_op.valid       = out_v_r;
  assign out_op.op_kind     = out_r.op_kind;
  assign out_op.send_peer   = out_r.send_peer;
  assign out_op.recv_peer   = out_r.recv_peer;
  assign out_op.send_amount = out_r.send_amount;
  assign out_op.recv_amount = out_r.recv_amount;
  assign out_op.algorithm   = out_r.algorithm;
  assign out_op.last        = out_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      hold_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      short_r   <= ShortReset;
      long_r    <= LongReset;
      min_grp_r <= MinGrpReset;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHORT:     short_r <= cfg_data[TotalW-1:0];
          CFG_LONG:      long_r <= cfg_data[TotalW-1:0];
          CFG_MIN_GROUP: min_grp_r <= cfg_data[GroupW-1:0];
          default: ;
        endcase
      end

      // Output register and staging word.
      if (cand_push && can_push) begin
        hold_r   <= cand;
        hold_v_r <= 1'b1;
        if (hold_v_r) begin
          out_r   <= hold_r;
          out_v_r <= 1'b1;
        end else if (out_op.ready) begin
          out_v_r <= 1'b0;
        end
      end else if (state_r == S_FLUSH && hold_v_r && out_free) begin
        // The last flag is the lowest bit of the word.
        out_r    <= {hold_r[$bits(op_t)-1:1], 1'b1};
        out_v_r  <= 1'b1;
        hold_v_r <= 1'b0;
      end else if (out_op.ready) begin
        out_v_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            me_r    <= in_req.my_rank;
            root_r  <= in_req.root_rank;
            n_r     <= in_req.group_size;
            count_r <= in_req.elem_count;
            esize_r <= in_req.elem_bytes;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          total_r <= TotalW'({7'd0, count_r} * {24'd0, esize_r});
          rel_r   <= rel_full[RankW-1:0];
          bad_r   <= (n_r == '0) || (n_r > 7'(MaxRanks)) || ({1'b0, me_r} >= n_r)
                     || ({1'b0, root_r} >= n_r);
          state_r <= S_SEL;
        end
        S_SEL: begin
          if (bad_r) begin
            state_r <= S_FLUSH;
          end else if (total_r < short_r || n_r < min_grp_r) begin
            alg_r   <= ALG_TREE;
            mask_r  <= (rel_r != 6'd0) ? {1'b0, lowbit >> 1} : top_mask;
            state_r <= S_TREE;
          end else if (n_r == 7'd1 || total_r == '0) begin
            state_r <= S_FLUSH;
          end else begin
            alg_r     <= (total_r < long_r && (n_r & n_m1) == '0) ? ALG_DOUBLING : ALG_RING;
            d_r       <= {1'b0, total_r} + {25'd0, n_m1};
            rem_r     <= '0;
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end
        end
        S_TREE: begin
          if (mask_r == '0) begin
            state_r <= S_FLUSH;
          end else if (!cand_push || can_push) begin
            mask_r <= mask_r >> 1;
          end
        end
        S_DIV: begin
          rem_r     <= div_ge ? 7'(div_t - {1'b0, n_r}) : div_t[GroupW-1:0];
          d_r       <= {d_r[DivW-2:0], div_ge};
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'd31) begin
            s_r     <= {d_r[DivW-3:0], div_ge};
            state_r <= (alg_r == ALG_DOUBLING) ? S_DBL_INIT : S_RING_M0;
            rj_r    <= rel_r;
            step_r  <= 7'd1;
          end
        end
        S_DBL_INIT: begin
          prod_r  <= mul_p;
          state_r <= S_DBL_H;
        end
        S_DBL_H: begin
          held_r  <= piece_v;
          mask_r  <= 7'd1;
          cap_r   <= {{RankW{1'b0}}, s_r};
          state_r <= S_DBL_M;
        end
        S_DBL_M: begin
          prod_r  <= mul_p;
          state_r <= S_DBL_E;
        end
        S_DBL_E: begin
          if (can_push) begin
            held_r  <= held_r + piece_v;
            mask_r  <= mask_r << 1;
            cap_r   <= cap_r << 1;
            state_r <= ({mask_r, 1'b0} >= {1'b0, n_r}) ? S_FLUSH : S_DBL_M;
          end
        end
        S_RING_M0: begin
          prod_r  <= mul_p;
          state_r <= S_RING_M1;
        end
        S_RING_M1: begin
          pa_r    <= piece_v;
          prod_r  <= mul_p;
          state_r <= S_RING_E;
        end
        S_RING_E: begin
          if (can_push) begin
            rj_r    <= rjn;
            step_r  <= step_r + 7'd1;
            state_r <= (step_r == n_m1) ? S_FLUSH : S_RING_M0;
          end
        end
        S_FLUSH: begin
          if (!hold_v_r || out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import bsg_pkg::*;

  // One broadcast request as the block sees it on its input channel.
  typedef struct {
    logic [RankW-1:0]  my_rank;
    logic [RankW-1:0]  root_rank;
    logic [GroupW-1:0] group_size;
    logic [CountW-1:0] elem_count;
    logic [EsizeW-1:0] elem_bytes;
  } bcast_req_t;

  localparam int StallLimit = 20000;
  localparam int DrainCycles = 200;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  bsg_req_if req_ch ();
  bsg_op_if  op_ch ();

  bcast_schedule_generator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_op    (op_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the threshold registers, kept in step with every write.
  logic [TotalW-1:0] short_thr;
  logic [TotalW-1:0] long_thr;
  logic [GroupW-1:0] min_group;

  bcast_req_t pending_reqs[$];
  op_t        expected_ops[$];
  int         err_count;
  int         send_idle_pct;
  int         recv_stall_pct;
  bit         req_fire;
  bit         hold_go;
  int         quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  // Bytes of the block at relative index rel, capped at cap, floored at zero.
  function automatic longint unsigned chunk_bytes(input longint unsigned rel,
                                                  input longint unsigned s,
                                                  input longint unsigned total,
                                                  input longint unsigned cap);
    longint unsigned off;
    off = rel * s;
    if (off >= total) return 0;
    return (total - off) < cap ? total - off : cap;
  endfunction

  function automatic logic [AmountW-1:0] clamp_amount(input longint unsigned v);
    return v > 64'h3FFF_FFFF ? {AmountW{1'b1}} : v[AmountW-1:0];
  endfunction

  function automatic op_t make_op(input op_kind_t kind, input longint unsigned sp,
                                  input longint unsigned rp, input longint unsigned sa,
                                  input longint unsigned ra, input alg_t alg);
    op_t o;
    o.op_kind     = kind;
    o.send_peer   = sp[RankW-1:0];
    o.recv_peer   = rp[RankW-1:0];
    o.send_amount = clamp_amount(sa);
    o.recv_amount = clamp_amount(ra);
    o.algorithm   = alg;
    o.last        = 1'b0;
    return o;
  endfunction

  // Works out this rank's operations for one request and appends them to the
  // store of expected words, with last set on the final one.
  task automatic schedule_ops(input bcast_req_t r);
    longint unsigned me, root, n, count, total, rel, mask, s, held;
    longint unsigned rdst, droot, roff, posted, dst, left, right, j, jn, rj, rjn;
    op_t ops[$];
    me    = r.my_rank;
    root  = r.root_rank;
    n     = r.group_size;
    count = r.elem_count;
    total = count * r.elem_bytes;
    if (n == 0 || n > MaxRanks || me >= n || root >= n) return;
    rel = (me + n - root) % n;
    if (total < short_thr || n < min_group) begin
      // Binomial tree: receive from the parent, then send to children by falling mask.
      mask = 1;
      while (mask < n) begin
        if ((rel & mask) != 0) begin
          ops.push_back(make_op(OP_RECV, 0, (me + n - mask) % n, 0, count, ALG_TREE));
          break;
        end
        mask <<= 1;
      end
      mask >>= 1;
      while (mask > 0) begin
        if (rel + mask < n) begin
          ops.push_back(make_op(OP_SEND, (me + mask) % n, 0, count, 0, ALG_TREE));
        end
        mask >>= 1;
      end
    end else if (total < long_thr && (n & (n - 1)) == 0) begin
      if (n == 1 || total == 0) return;
      s = (total + n - 1) / n;
      held = chunk_bytes(rel, s, total, s);
      for (mask = 1; mask < n; mask <<= 1) begin
        rdst = rel ^ mask;
        droot = rdst & ~(mask - 1);
        roff = droot * s;
        posted = roff < total ? total - roff : 0;
        if (rdst < n) begin
          dst = (rdst + root) % n;
          ops.push_back(make_op(OP_SENDRECV, dst, dst, held, posted, ALG_DOUBLING));
          // The holding grows by the peer subtree's clamped share.
          held += chunk_bytes(droot, s, total, mask * s);
        end
      end
    end else begin
      if (n == 1 || total == 0) return;
      s = (total + n - 1) / n;
      left = (me + n - 1) % n;
      right = (me + 1) % n;
      j = me;
      jn = left;
      for (longint unsigned i = 1; i < n; i++) begin
        rj = (j + n - root) % n;
        rjn = (jn + n - root) % n;
        ops.push_back(make_op(OP_SENDRECV, right, left, chunk_bytes(rj, s, total, s),
                              chunk_bytes(rjn, s, total, s), ALG_RING));
        j = jn;
        jn = (jn + n - 1) % n;
      end
    end
    if (ops.size() > 0) ops[ops.size()-1].last = 1'b1;
    foreach (ops[k]) expected_ops.push_back(ops[k]);
  endtask

  // Input side: a new word is offered once the previous one has been taken.
  always @(negedge clk) begin
    bcast_req_t r;
    if (rst_n) begin
      if (!req_ch.valid || req_fire) begin
        req_fire = 1'b0;
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          req_ch.my_rank    <= r.my_rank;
          req_ch.root_rank  <= r.root_rank;
          req_ch.group_size <= r.group_size;
          req_ch.elem_count <= r.elem_count;
          req_ch.elem_bytes <= r.elem_bytes;
          req_ch.valid      <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off counted here so that
  // the block fills up and stops taking requests.
  always @(negedge clk) begin
    int hold_left;
    if (rst_n) begin
      if (hold_go && hold_left == 0) begin
        hold_left = 600;
        hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        op_ch.ready <= 1'b0;
      end else begin
        op_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Prediction on every accepted request, checking on every accepted word,
  // and a watchdog on stretches with no handshake at all.
  always @(posedge clk) begin
    bcast_req_t r;
    op_t got, want;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        r.my_rank    = req_ch.my_rank;
        r.root_rank  = req_ch.root_rank;
        r.group_size = req_ch.group_size;
        r.elem_count = req_ch.elem_count;
        r.elem_bytes = req_ch.elem_bytes;
        schedule_ops(r);
        req_fire = 1'b1;
        moved = 1'b1;
      end
      if (op_ch.valid && op_ch.ready) begin
        moved = 1'b1;
        got.op_kind     = op_ch.op_kind;
        got.send_peer   = op_ch.send_peer;
        got.recv_peer   = op_ch.recv_peer;
        got.send_amount = op_ch.send_amount;
        got.recv_amount = op_ch.recv_amount;
        got.algorithm   = op_ch.algorithm;
        got.last        = op_ch.last;
        if (expected_ops.size() == 0) begin
          report_mismatch("word with nothing expected, op_kind", got.op_kind, -1);
        end else begin
          want = expected_ops.pop_front();
          if (got.op_kind !== want.op_kind)
            report_mismatch("op_kind", got.op_kind, want.op_kind);
          if (got.send_peer !== want.send_peer)
            report_mismatch("send_peer", got.send_peer, want.send_peer);
          if (got.recv_peer !== want.recv_peer)
            report_mismatch("recv_peer", got.recv_peer, want.recv_peer);
          if (got.send_amount !== want.send_amount)
            report_mismatch("send_amount", got.send_amount, want.send_amount);
          if (got.recv_amount !== want.recv_amount)
            report_mismatch("recv_amount", got.recv_amount, want.recv_amount);
          if (got.algorithm !== want.algorithm)
            report_mismatch("algorithm", got.algorithm, want.algorithm);
          if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SHORT:     short_thr = value;
      CFG_LONG:      long_thr = value;
      CFG_MIN_GROUP: min_group = value[GroupW-1:0];
      default: begin
      end
    endcase
  endtask

  function automatic bcast_req_t make_req(input int me, input int root, input int n,
                                          input int count, input int esize);
    bcast_req_t r;
    r.my_rank    = RankW'(me);
    r.root_rank  = RankW'(root);
    r.group_size = GroupW'(n);
    r.elem_count = CountW'(count);
    r.elem_bytes = EsizeW'(esize);
    return r;
  endfunction

  // The corner cases: a group of one, the largest group from both ends, zero
  // bytes, a saturating byte total, chunks that run out before the last rank,
  // and requests the block must ignore.
  task automatic queue_corner_reqs();
    pending_reqs.push_back(make_req(0, 0, 1, 100, 4));
    pending_reqs.push_back(make_req(63, 0, 64, 5000, 8));
    pending_reqs.push_back(make_req(0, 63, 64, 70000, 16));
    pending_reqs.push_back(make_req(17, 17, 64, 1000, 64));
    pending_reqs.push_back(make_req(3, 1, 8, 0, 1));
    pending_reqs.push_back(make_req(5, 2, 48, 0, 64));
    pending_reqs.push_back(make_req(63, 31, 64, 24'hFFFFFF, 127));
    pending_reqs.push_back(make_req(1, 0, 32, 1, 1));
    pending_reqs.push_back(make_req(6, 3, 8, 5, 1));
    pending_reqs.push_back(make_req(44, 9, 48, 24'hFFFFFF, 64));
    pending_reqs.push_back(make_req(7, 0, 16, 300000, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 10, 1));
    pending_reqs.push_back(make_req(0, 0, 65, 10, 1));
    pending_reqs.push_back(make_req(0, 0, 127, 10, 1));
    pending_reqs.push_back(make_req(8, 0, 8, 10, 1));
    pending_reqs.push_back(make_req(0, 8, 8, 10, 1));
    pending_reqs.push_back(make_req(2, 1, 3, 9000, 1));
  endtask

  // Mostly well-formed requests with random content; roughly one in ten is
  // noise over the full field widths, which is often ignored.
  task automatic queue_random_reqs(input int num);
    bcast_req_t r;
    int n, sel, done_cnt;
    done_cnt = 0;
    while (done_cnt < num) begin
      if ($urandom_range(9) == 0) begin
        r.my_rank    = RankW'($urandom);
        r.root_rank  = RankW'($urandom);
        r.group_size = GroupW'($urandom);
        r.elem_count = CountW'($urandom);
        r.elem_bytes = EsizeW'($urandom);
      end else begin
        sel = $urandom_range(3);
        n = (sel == 0) ? (1 << $urandom_range(6)) : $urandom_range(1, MaxRanks);
        r.group_size = GroupW'(n);
        r.my_rank    = RankW'($urandom_range(n - 1));
        r.root_rank  = RankW'($urandom_range(n - 1));
        sel = $urandom_range(3);
        r.elem_count = CountW'((sel == 0) ? $urandom_range(40) :
                               (sel == 1) ? $urandom_range(20000) :
                               (sel == 2) ? $urandom_range(2000000) : $urandom);
        r.elem_bytes = EsizeW'(($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 64));
      end
      pending_reqs.push_back(r);
      if (r.group_size >= 1 && r.group_size <= MaxRanks && r.my_rank < r.group_size &&
          r.root_rank < r.group_size)
        done_cnt++;
    end
  endtask

  // A phase ends once every request is taken and every word has come back;
  // the extra cycles cover requests that produce no words at all.
  task automatic drain();
    wait (pending_reqs.size() == 0 && !req_ch.valid && expected_ops.size() == 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SHORT;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.my_rank = '0;
    req_ch.root_rank = '0;
    req_ch.group_size = '0;
    req_ch.elem_count = '0;
    req_ch.elem_bytes = '0;
    op_ch.ready = 1'b0;
    short_thr = ShortReset;
    long_thr = LongReset;
    min_group = MinGrpReset;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    req_fire = 1'b0;
    hold_go = 1'b0;
    quiet_cycles = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Thresholds as they come out of reset, no idling on either side.
    queue_corner_reqs();
    queue_random_reqs(80);
    drain();

    // Allgather everywhere: doubling for powers of two with totals under 2^30 bytes, ring for the rest.
    // The sender idles heavily and the receiver holds off for a long while.
    write_reg(CFG_SHORT, 31'd0);
    write_reg(CFG_LONG, 31'd1073741824);
    write_reg(CFG_MIN_GROUP, 31'd1);
    send_idle_pct = 74;
    hold_go = 1'b1;
    queue_corner_reqs();
    queue_random_reqs(80);
    drain();

    // Ring only, with the receiver stalling most of the time.
    write_reg(CFG_LONG, 31'd0);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    queue_random_reqs(80);
    drain();

    // Mostly tree: short threshold at 2^30 bytes, long at its top end, group threshold at 64.
    write_reg(CFG_SHORT, 31'd1073741824);
    write_reg(CFG_LONG, 31'h7FFF_FFFF);
    write_reg(CFG_MIN_GROUP, 31'd64);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    queue_random_reqs(80);
    drain();

    // Odd register values, including a group threshold nothing can reach.
    write_reg(CFG_SHORT, 31'h7FFF_FFFF);
    write_reg(CFG_MIN_GROUP, 31'd127);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_reqs(20);
    drain();

    // Random thresholds that split requests over all three algorithms.
    write_reg(CFG_SHORT, CfgDataW'($urandom_range(20000)));
    write_reg(CFG_LONG, CfgDataW'($urandom_range(20000, 4000000)));
    write_reg(CFG_MIN_GROUP, CfgDataW'($urandom_range(1, 16)));
    send_idle_pct = 11;
    recv_stall_pct = 11;
    queue_random_reqs(80);
    drain();

    write_reg(CFG_MIN_GROUP, 31'd0);
    send_idle_pct = 74;
    recv_stall_pct = 74;
    queue_random_reqs(60);
    drain();

    if (expected_ops.size() > 0)
      report_mismatch("words never delivered", 0, expected_ops.size());
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
